FILE: rtl/pid_pkg.sv
// ---------------------------------------------------------------------------
// PID step package
// Widths, register indexes and the control bundle of the digit-serial
// multiplier shared by the PID step datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package pid_pkg;

  // Field widths
  localparam int unsigned VAL_W   = 32;  // Q16.16 values and gains
  localparam int unsigned CFG16_W = 16;  // time step and rate
  localparam int unsigned ACC_W   = 48;  // Q32.16 integral, derivative, terms
  localparam int unsigned SUM_W   = ACC_W + 2;

  // Multiplier geometry: multiplicand is a sign-extended 33 bit value,
  // the multiplier operand is consumed one digit per cycle
  localparam int unsigned A_W      = VAL_W + 1;
  localparam int unsigned X_W      = ACC_W;
  localparam int unsigned DIG_W    = 4;
  localparam int unsigned HI_W     = A_W + DIG_W + 1;
  localparam int unsigned NDIG_SH  = CFG16_W / DIG_W;
  localparam int unsigned NDIG_LG  = X_W / DIG_W;
  localparam int unsigned CNT_W    = $clog2(NDIG_LG);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE = 3'd4;

  // Reset values of the timing registers
  localparam logic [CFG16_W-1:0] TS_RST   = 16'd65;
  localparam logic [CFG16_W-1:0] RATE_RST = 16'd1000;

  // Saturation bounds
  localparam logic [VAL_W-1:0] MAX32 = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] MIN32 = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] MAX48 = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] MIN48 = {1'b1, {(ACC_W-1){1'b0}}};

  // Request to the multiplier
  typedef struct packed {
    logic             start;
    logic             b_signed;  // top digit of the operand carries sign weight
    logic [CNT_W-1:0] last_idx;  // digit count minus one
  } mul_ctl_t;

endpackage : pid_pkg

`default_nettype wire

FILE: rtl/pid_mul.sv
// ---------------------------------------------------------------------------
// PID digit-serial multiplier
// Signed 33 bit multiplicand times a 48 bit operand taken four bits a cycle
// from the bottom; returns the high part and the low product bits.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_mul
  import pid_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire mul_ctl_t               ctl,
  input  wire logic signed [A_W-1:0]  a_in,
  input  wire logic        [X_W-1:0]  b_in,
  output logic                        done,
  output logic signed [HI_W-1:0]      hi,
  output logic        [X_W-1:0]       lo
);

  logic                    busy_r;
  logic                    done_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    sgn_r;
  logic signed [A_W-1:0]   a_r;
  logic        [X_W-1:0]   b_r;
  logic signed [HI_W-1:0]  hi_r;

  logic                    last_dig;
  logic signed [DIG_W:0]   dig;
  logic signed [HI_W-1:0]  prod;
  logic signed [HI_W-1:0]  hi_sum;
  logic signed [HI_W-1:0]  hi_nxt;
  logic        [X_W-1:0]   b_nxt;

  // One digit step: add multiplicand times digit, shift one digit right.
  // The final digit of a signed operand has negative weight on its top bit.
  always_comb begin
    last_dig = (cnt_r == '0);
    dig      = {sgn_r & last_dig & b_r[DIG_W-1], b_r[DIG_W-1:0]};
    prod     = HI_W'(a_r) * HI_W'(dig);
    hi_sum   = hi_r + prod;
    hi_nxt   = hi_sum >>> DIG_W;
    b_nxt    = {hi_sum[DIG_W-1:0], b_r[X_W-1:DIG_W]};
  end

  // Sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.last_idx;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (last_dig) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands and partial product
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r   <= a_in;
      b_r   <= b_in;
      sgn_r <= ctl.b_signed;
      hi_r  <= '0;
    end else if (busy_r) begin
      b_r  <= b_nxt;
      hi_r <= hi_nxt;
    end
  end

  assign done = done_r;
  assign hi   = hi_r;
  assign lo   = b_r;

endmodule : pid_mul

`default_nettype wire

FILE: rtl/pid_controller_step.sv
// ---------------------------------------------------------------------------
// PID controller step
// Parallel-form PID in signed fixed point with saturating integral and a
// clip flag, built around one shared digit-serial multiplier.
// ---------------------------------------------------------------------------
// Each input transaction (target, measured, Q16.16) yields one result
// transaction: control_out = Kp*e + Ki*integral + Kd*derivative, saturated
// to 32 bits, with saturated set when any step clipped. The five products
// (e*time_step, de*rate_hz, and the three gain terms) run one after another
// through a multiplier that takes 4 bits of its operand per cycle, in 4 +
// 4 + 12 + 12 + 12 digit steps; the result is then registered. in_ready is
// high only while the datapath is idle; a finished result waits in the
// output register without holding back the next transaction. Configuration
// writes take effect at once and should be made while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_controller_step
  import pid_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // configuration
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [VAL_W-1:0]           cfg_data,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [VAL_W-1:0]    in_target_value,
  input  wire logic signed [VAL_W-1:0]    in_measured_value,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [VAL_W-1:0]         out_control_out,
  output logic                            out_saturated
);

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_TS, S_RATE, S_P, S_I, S_D, S_SUM, S_OUT
  } state_t;

  state_t                  state_r;
  logic                    out_valid_r;
  logic [VAL_W-1:0]        out_ctl_r;
  logic                    out_sat_r;

  logic [VAL_W-1:0]        kp_r, ki_r, kd_r;
  logic [CFG16_W-1:0]      ts_r, rate_r;
  logic [VAL_W-1:0]        last_r;
  logic [ACC_W-1:0]        integ_r;

  logic [VAL_W-1:0]        tgt_r, meas_r;
  logic [VAL_W-1:0]        e_r;
  logic [A_W-1:0]          de_r;
  logic [ACC_W-1:0]        d_r;
  logic [SUM_W-1:0]        sum_r;
  logic [VAL_W-1:0]        res_r;
  logic                    flag_r;

  mul_ctl_t                mctl;
  logic signed [A_W-1:0]   ma;
  logic        [X_W-1:0]   mb;
  logic                    mdone;
  logic signed [HI_W-1:0]  mhi;
  logic        [X_W-1:0]   mlo;

  logic                    accept;
  logic                    out_free;
  logic [A_W-1:0]          diff;
  logic                    e_ovf;
  logic [VAL_W-1:0]        e_clip;
  logic [A_W-1:0]          de;
  logic [ACC_W:0]          integ_sum;
  logic                    integ_ovf;
  logic [ACC_W-1:0]        integ_clip;
  logic                    d_fit;
  logic [ACC_W-1:0]        d_clip;
  logic                    term_fit;
  logic [ACC_W-1:0]        term_clip;
  logic [SUM_W-1:0]        sum_nxt;
  logic                    sum_fit;
  logic [VAL_W-1:0]        sum_clip;

  assign accept   = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;
  assign in_ready = (state_r == S_IDLE);

  // Error, clipped to 32 bits, and its change since the last transaction
  always_comb begin
    diff   = {tgt_r[VAL_W-1], tgt_r} - {meas_r[VAL_W-1], meas_r};
    e_ovf  = diff[A_W-1] ^ diff[VAL_W-1];
    e_clip = e_ovf ? (diff[A_W-1] ? MIN32 : MAX32) : diff[VAL_W-1:0];
    de     = {e_clip[VAL_W-1], e_clip} - {last_r[VAL_W-1], last_r};
  end

  // Integral update from floor(e * time_step / 2^16)
  always_comb begin
    integ_sum  = {integ_r[ACC_W-1], integ_r}
               + {{(ACC_W+1-VAL_W){mhi[VAL_W-1]}}, mhi[VAL_W-1:0]};
    integ_ovf  = integ_sum[ACC_W] ^ integ_sum[ACC_W-1];
    integ_clip = integ_ovf ? (integ_sum[ACC_W] ? MIN48 : MAX48)
                           : integ_sum[ACC_W-1:0];
  end

  // Derivative: product = hi * 2^16 + low 16; fits 48 bits when hi fits 32
  always_comb begin
    d_fit  = (&mhi[HI_W-1:VAL_W-1]) | ~(|mhi[HI_W-1:VAL_W-1]);
    d_clip = d_fit ? {mhi[VAL_W-1:0], mlo[X_W-1:X_W-CFG16_W]}
                   : (mhi[HI_W-1] ? MIN48 : MAX48);
  end

  // Gain term: floor(product / 2^16) = hi * 2^32 + upper 32 of the low part
  always_comb begin
    term_fit  = (&mhi[HI_W-1:ACC_W-VAL_W-1]) | ~(|mhi[HI_W-1:ACC_W-VAL_W-1]);
    term_clip = term_fit ? {mhi[ACC_W-VAL_W-1:0], mlo[X_W-1:X_W-VAL_W]}
                         : (mhi[HI_W-1] ? MIN48 : MAX48);
    sum_nxt   = sum_r + {{(SUM_W-ACC_W){term_clip[ACC_W-1]}}, term_clip};
  end

  // Final sum clipped to 32 bits
  always_comb begin
    sum_fit  = (&sum_r[SUM_W-1:VAL_W-1]) | ~(|sum_r[SUM_W-1:VAL_W-1]);
    sum_clip = sum_fit ? sum_r[VAL_W-1:0] : (sum_r[SUM_W-1] ? MIN32 : MAX32);
  end

  // Multiplier requests, one per product
  always_comb begin
    mctl.start    = 1'b0;
    mctl.b_signed = 1'b0;
    mctl.last_idx = CNT_W'(NDIG_SH - 1);
    ma            = '0;
    mb            = '0;
    case (state_r)
      S_ERR: begin
        mctl.start = 1'b1;
        ma         = {e_clip[VAL_W-1], e_clip};
        mb         = {{(X_W-CFG16_W){1'b0}}, ts_r};
      end
      S_TS: begin
        mctl.start = mdone;
        ma         = de_r;
        mb         = {{(X_W-CFG16_W){1'b0}}, rate_r};
      end
      S_RATE: begin
        mctl.start    = mdone;
        mctl.b_signed = 1'b1;
        mctl.last_idx = CNT_W'(NDIG_LG - 1);
        ma            = {kp_r[VAL_W-1], kp_r};
        mb            = {{(X_W-VAL_W){e_r[VAL_W-1]}}, e_r};
      end
      S_P: begin
        mctl.start    = mdone;
        mctl.b_signed = 1'b1;
        mctl.last_idx = CNT_W'(NDIG_LG - 1);
        ma            = {ki_r[VAL_W-1], ki_r};
        mb            = integ_r;
      end
      S_I: begin
        mctl.start    = mdone;
        mctl.b_signed = 1'b1;
        mctl.last_idx = CNT_W'(NDIG_LG - 1);
        ma            = {kd_r[VAL_W-1], kd_r};
        mb            = d_r;
      end
      default: begin
      end
    endcase
  end

  pid_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .a_in  (ma),
    .b_in  (mb),
    .done  (mdone),
    .hi    (mhi),
    .lo    (mlo)
  );

  // Sequencer, configuration, controller state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      ts_r        <= TS_RST;
      rate_r      <= RATE_RST;
      last_r      <= '0;
      integ_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KP:   kp_r   <= cfg_data;
          CFG_KI:   ki_r   <= cfg_data;
          CFG_KD:   kd_r   <= cfg_data;
          CFG_TS:   ts_r   <= cfg_data[CFG16_W-1:0];
          CFG_RATE: rate_r <= cfg_data[CFG16_W-1:0];
          default: begin
          end
        endcase
      end

      // result leaves; in S_OUT a new result takes its place instead
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_ERR;
          end
        end
        S_ERR: begin
          last_r  <= e_clip;
          state_r <= S_TS;
        end
        S_TS: begin
          if (mdone) begin
            integ_r <= integ_clip;
            state_r <= S_RATE;
          end
        end
        S_RATE: begin
          if (mdone) begin
            state_r <= S_P;
          end
        end
        S_P: begin
          if (mdone) begin
            state_r <= S_I;
          end
        end
        S_I: begin
          if (mdone) begin
            state_r <= S_D;
          end
        end
        S_D: begin
          if (mdone) begin
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers of the transaction in flight
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          tgt_r  <= in_target_value;
          meas_r <= in_measured_value;
          sum_r  <= '0;
          flag_r <= 1'b0;
        end
      end
      S_ERR: begin
        e_r  <= e_clip;
        de_r <= de;
        if (e_ovf) begin
          flag_r <= 1'b1;
        end
      end
      S_TS: begin
        if (mdone && integ_ovf) begin
          flag_r <= 1'b1;
        end
      end
      S_RATE: begin
        if (mdone) begin
          d_r <= d_clip;
          if (!d_fit) begin
            flag_r <= 1'b1;
          end
        end
      end
      S_P, S_I, S_D: begin
        if (mdone) begin
          sum_r <= sum_nxt;
          if (!term_fit) begin
            flag_r <= 1'b1;
          end
        end
      end
      S_SUM: begin
        res_r <= sum_clip;
        if (!sum_fit) begin
          flag_r <= 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_ctl_r <= res_r;
          out_sat_r <= flag_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_control_out = out_ctl_r;
  assign out_saturated   = out_sat_r;

endmodule : pid_controller_step

`default_nettype wire
